// ===== src/cgcl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgcl_pkg
// Shared types and constants for the cylindrical grid cell locator.
// ----------------------------------------------------------------------------
package cgcl_pkg;

  localparam int DATA_W = 32;

  // item kinds
  typedef enum logic [1:0] {
    KIND_LOAD_RADIAL   = 2'd0,
    KIND_LOAD_VERTICAL = 2'd1,
    KIND_LOAD_CELL     = 2'd2,
    KIND_LOCATE        = 2'd3
  } kind_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_NUM_RADIAL   = 2'd0,
    CFG_NUM_VERTICAL = 2'd1,
    CFG_PHI_PERIOD   = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_index_t;

  localparam logic [6:0]  RESET_NUM_RADIAL   = 7'd64;
  localparam logic [2:0]  RESET_NUM_VERTICAL = 3'd1;
  localparam logic [30:0] RESET_PHI_PERIOD   = 31'd411775;

  // locate sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_RADDR,
    S_RCMP,
    S_VADDR,
    S_VCMP,
    S_JK,
    S_CHK,
    S_CNT,
    S_CELL,
    S_CWAIT,
    S_DIV,
    S_WRAP,
    S_EVAL,
    S_DONE
  } state_t;

endpackage

// ===== src/cylindrical_grid_cell_locator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cylindrical_grid_cell_locator_top
// Locates the cylindrical mesh cell holding a particle (r, z, phi).
// ----------------------------------------------------------------------------
// Load items (radial edge, vertical edge, cell) are written on the edge that
// accepts them. A locate item runs two lower-bound searches over the edge
// memories, each step an address state then a compare state, plus one closing
// address state per search, then scans the annulus cells one memory read at a
// time. With a nonzero period each scanned cell goes through the bit-serial
// 32-step remainder that wraps phi into the half-period range; with a zero
// period that remainder is skipped. When the scan runs out without a match, a
// final cell state ends it. Once the result is registered, which waits while a
// held result is stalled, the block returns to idle and takes its next item.
// The result waits in an output register, so loads are taken while it is
// held. Only one locate is in flight; no clearing pass is needed after reset.
module cylindrical_grid_cell_locator_top #(
  parameter int MAX_RADIAL   = 64,
  parameter int MAX_VERTICAL = 4,
  parameter int MAX_CELLS    = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [30:0]          cfg_data,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           kind,
  input  logic [7:0]           entry_index,
  input  logic [5:0]           slot,
  input  logic signed [31:0]   value_a,
  input  logic signed [31:0]   value_b,
  input  logic [6:0]           cell_count,
  input  logic signed [31:0]   pos_r,
  input  logic signed [31:0]   pos_z,
  input  logic signed [31:0]   pos_phi,
  // output channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 found,
  output logic [6:0]           radial_index,
  output logic [2:0]           vertical_index,
  output logic [7:0]           annulus_index,
  output logic [5:0]           cell_slot
);
  import cgcl_pkg::*;

  localparam int NUM_ANNULI = MAX_RADIAL * MAX_VERTICAL;
  localparam int NUM_CELLS  = NUM_ANNULI * MAX_CELLS;
  localparam int RW = $clog2(MAX_RADIAL + 1);
  localparam int VW = $clog2(MAX_VERTICAL + 1);
  localparam int CW = $clog2(MAX_CELLS + 1);
  localparam int JW = RW + VW;
  localparam int RA = (MAX_RADIAL > 1) ? $clog2(MAX_RADIAL) : 1;
  localparam int VA = (MAX_VERTICAL > 1) ? $clog2(MAX_VERTICAL) : 1;
  localparam int NA = (NUM_ANNULI > 1) ? $clog2(NUM_ANNULI) : 1;
  localparam int CA = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;

  // configuration registers
  logic [6:0]  num_radial;
  logic [2:0]  num_vertical;
  logic [30:0] phi_period;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_radial   <= RESET_NUM_RADIAL;
      num_vertical <= RESET_NUM_VERTICAL;
      phi_period   <= RESET_PHI_PERIOD;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_NUM_RADIAL:   num_radial   <= cfg_data[6:0];
        CFG_NUM_VERTICAL: num_vertical <= cfg_data[2:0];
        CFG_PHI_PERIOD:   phi_period   <= cfg_data;
        default: ;
      endcase
    end
  end

  state_t state, state_next;

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  // load decode
  logic rad_we, vert_we, cell_we;
  logic [CA-1:0] cell_waddr;
  logic [CW-1:0] cnt_wdata;
  always_comb begin
    rad_we  = in_acc && (kind_t'(kind) == KIND_LOAD_RADIAL)
              && (32'(entry_index) < MAX_RADIAL);
    vert_we = in_acc && (kind_t'(kind) == KIND_LOAD_VERTICAL)
              && (32'(entry_index) < MAX_VERTICAL);
    cell_we = in_acc && (kind_t'(kind) == KIND_LOAD_CELL)
              && (32'(entry_index) < NUM_ANNULI) && (32'(slot) < MAX_CELLS);
    cell_waddr = CA'(32'(entry_index) * MAX_CELLS + 32'(slot));
    cnt_wdata  = (32'(cell_count) > MAX_CELLS) ? CW'(MAX_CELLS) : CW'(cell_count);
  end

  // locate working registers
  logic signed [31:0] tgt_r, tgt_z, phi;
  logic [RW-1:0] nr, lo_r, hi_r, mid_r;
  logic [VW-1:0] nv, lo_v, hi_v, mid_v;
  logic [JW-1:0] jk;
  logic [CA-1:0] base;
  logic [CW-1:0] cnt, idx;
  logic signed [32:0] d;
  logic [31:0] dq, rem;
  logic [5:0]  bitcnt;
  logic signed [33:0] dw;
  logic signed [31:0] cw_reg;
  logic res_found;

  // memory read addresses
  logic [RA-1:0] rad_raddr;
  logic [VA-1:0] vert_raddr;
  logic [NA-1:0] cnt_raddr;
  logic [CA-1:0] cell_raddr;
  logic [RW-1:0] mid_r_c;
  logic [VW-1:0] mid_v_c;

  always_comb begin
    mid_r_c    = lo_r + ((hi_r - lo_r) >> 1);
    mid_v_c    = lo_v + ((hi_v - lo_v) >> 1);
    rad_raddr  = RA'(mid_r_c);
    vert_raddr = VA'(mid_v_c);
    cnt_raddr  = NA'(jk);
    cell_raddr = base + CA'(idx);
    in_stall   = (state != S_IDLE);
  end

  // memories
  logic signed [31:0] rad_mem [MAX_RADIAL];
  logic signed [31:0] vert_mem [MAX_VERTICAL];
  logic [CW-1:0]      cnt_mem [NUM_ANNULI];
  logic [63:0]        cell_mem [NUM_CELLS];
  logic [NUM_ANNULI-1:0] cnt_valid;
  logic signed [31:0] rad_rdata, vert_rdata;
  logic [CW-1:0]      cnt_rdata;
  logic               cnt_vld_rdata;
  logic [63:0]        cell_rdata;

  always_ff @(posedge clk) begin
    if (rad_we) rad_mem[RA'(entry_index)] <= value_a;
    rad_rdata <= rad_mem[rad_raddr];
  end

  always_ff @(posedge clk) begin
    if (vert_we) vert_mem[VA'(entry_index)] <= value_a;
    vert_rdata <= vert_mem[vert_raddr];
  end

  always_ff @(posedge clk) begin
    if (cell_we) begin
      cell_mem[cell_waddr] <= {value_a, value_b};
      cnt_mem[NA'(entry_index)] <= cnt_wdata;
    end
    cell_rdata <= cell_mem[cell_raddr];
    cnt_rdata  <= cnt_mem[cnt_raddr];
  end

  // per-annulus valid bits: an unwritten count reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_valid     <= '0;
      cnt_vld_rdata <= 1'b0;
    end else begin
      if (cell_we) cnt_valid[NA'(entry_index)] <= 1'b1;
      cnt_vld_rdata <= cnt_valid[cnt_raddr];
    end
  end

  // wrap and match arithmetic
  logic [31:0] rem_shift, m_val, neg_mag;
  logic [32:0] twom;
  logic signed [33:0] dw_wrap, s_sum;
  logic in_range, idx_ok, div_last;

  always_comb begin
    neg_mag   = -d[31:0];
    rem_shift = {rem[30:0], dq[31]};
    m_val = (d[32] && (rem != '0)) ? ({1'b0, phi_period} - rem) : rem;
    twom  = {m_val, 1'b0};
    if (twom > {2'b00, phi_period})
      dw_wrap = $signed({2'b00, m_val}) - $signed({3'b000, phi_period});
    else if (twom == {2'b00, phi_period} && d[32])
      dw_wrap = -$signed({2'b00, m_val});
    else
      dw_wrap = $signed({2'b00, m_val});
    s_sum    = dw + 34'(cw_reg);
    in_range = (s_sum > 0) && (dw < 0);
    idx_ok   = (idx < cnt);
    div_last = (bitcnt == 6'd31);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_acc && kind_t'(kind) == KIND_LOCATE) state_next = S_RADDR;
      S_RADDR: state_next = (lo_r < hi_r) ? S_RCMP : S_VADDR;
      S_RCMP:  state_next = S_RADDR;
      S_VADDR: state_next = (lo_v < hi_v) ? S_VCMP : S_JK;
      S_VCMP:  state_next = S_VADDR;
      S_JK:    state_next = S_CHK;
      S_CHK:   state_next = (lo_r < nr && lo_v < nv && 32'(jk) < NUM_ANNULI)
                            ? S_CNT : S_DONE;
      S_CNT:   state_next = S_CELL;
      S_CELL:  state_next = idx_ok ? S_CWAIT : S_DONE;
      S_CWAIT: state_next = (phi_period == '0) ? S_EVAL : S_DIV;
      S_DIV:   if (div_last) state_next = S_WRAP;
      S_WRAP:  state_next = S_EVAL;
      S_EVAL:  state_next = in_range ? S_DONE : S_CELL;
      S_DONE:  if (!out_valid || !out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        tgt_r <= pos_r;
        tgt_z <= pos_z;
        phi   <= pos_phi;
        nr    <= (32'(num_radial) > MAX_RADIAL) ? RW'(MAX_RADIAL) : RW'(num_radial);
        nv    <= (32'(num_vertical) > MAX_VERTICAL) ? VW'(MAX_VERTICAL)
                                                    : VW'(num_vertical);
        lo_r  <= '0;
        lo_v  <= '0;
        hi_r  <= (32'(num_radial) > MAX_RADIAL) ? RW'(MAX_RADIAL) : RW'(num_radial);
        hi_v  <= (32'(num_vertical) > MAX_VERTICAL) ? VW'(MAX_VERTICAL)
                                                    : VW'(num_vertical);
        res_found <= 1'b0;
        idx   <= '0;
        cnt   <= '0;
      end
      S_RADDR: mid_r <= mid_r_c;
      S_RCMP: begin
        if (rad_rdata < tgt_r) lo_r <= mid_r + RW'(1);
        else                   hi_r <= mid_r;
      end
      S_VADDR: mid_v <= mid_v_c;
      S_VCMP: begin
        if (vert_rdata < tgt_z) lo_v <= mid_v + VW'(1);
        else                    hi_v <= mid_v;
      end
      S_JK: jk <= JW'(32'(lo_r) + 32'(nr) * 32'(lo_v));
      S_CHK: base <= CA'(32'(jk) * MAX_CELLS);
      S_CNT: cnt <= cnt_vld_rdata ? cnt_rdata : '0;
      S_CWAIT: begin
        d      <= 33'(phi) - 33'($signed(cell_rdata[63:32]));
        cw_reg <= cell_rdata[31:0];
        dq     <= 32'(phi) - cell_rdata[63:32];
        rem    <= '0;
        bitcnt <= '0;
        dw     <= 34'(33'(phi) - 33'($signed(cell_rdata[63:32])));
      end
      S_DIV: begin
        // first step turns the two's-complement difference into a magnitude
        if (bitcnt == '0 && d[32]) begin
          dq  <= neg_mag << 1;
          rem <= ({31'b0, neg_mag[31]} >= {1'b0, phi_period})
                 ? ({31'b0, neg_mag[31]} - {1'b0, phi_period})
                 : {31'b0, neg_mag[31]};
        end else begin
          dq  <= dq << 1;
          rem <= (rem_shift >= {1'b0, phi_period}) ? rem_shift - {1'b0, phi_period}
                                                   : rem_shift;
        end
        bitcnt <= bitcnt + 6'd1;
      end
      S_WRAP: dw <= dw_wrap;
      S_EVAL: begin
        if (in_range) res_found <= 1'b1;
        else          idx <= idx + CW'(1);
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || !out_stall)) begin
      found          <= res_found;
      radial_index   <= 7'(lo_r);
      vertical_index <= 3'(lo_v);
      annulus_index  <= 8'(jk);
      cell_slot      <= res_found ? 6'(idx) : 6'd0;
    end
  end

endmodule

// ===== src/cgcl_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgcl_port_checks
// Port-level checks for the cylindrical grid cell locator.
// ----------------------------------------------------------------------------
module cgcl_port_checks (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       found,
  input logic [6:0] radial_index,
  input logic [2:0] vertical_index,
  input logic [7:0] annulus_index,
  input logic [5:0] cell_slot
);

  // a held result does not change
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(found) && $stable(cell_slot)
      && $stable(annulus_index) && $stable(radial_index) && $stable(vertical_index))
    else $error("held result changed");

  // a miss reports slot zero
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> cell_slot == 6'd0)
    else $error("miss with nonzero slot");

  // a new result only comes out of a busy locate
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a locate in progress");

  // nothing comes out right after reset
  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind cylindrical_grid_cell_locator_top cgcl_port_checks u_cgcl_port_checks (
  .clk            (clk),
  .rst            (rst),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .found          (found),
  .radial_index   (radial_index),
  .vertical_index (vertical_index),
  .annulus_index  (annulus_index),
  .cell_slot      (cell_slot)
);
